@@ rtl/global_average_pool_unit_macros.svh @@
// ----------------------------------------------------------------------------
// global_average_pool_unit_macros.svh
// Assertion macros of the pooling unit port checker.
// ----------------------------------------------------------------------------
`ifndef GLOBAL_AVERAGE_POOL_UNIT_MACROS_SVH
`define GLOBAL_AVERAGE_POOL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/gap_pkg.sv @@
// ----------------------------------------------------------------------------
// gap_pkg
// Widths, limits, register indexes and the queue item of the pooling unit.
// ----------------------------------------------------------------------------
package gap_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned CH_W          = 10;
  localparam int unsigned POS_W         = 12;
  localparam int unsigned NC_W          = 11;
  localparam int unsigned NP_W          = 13;
  localparam int unsigned RECIP_W       = 17;
  localparam int unsigned SUM_W         = 28;
  localparam int unsigned PROD_W        = SUM_W + RECIP_W + 1;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned MAX_CHANNELS  = 1024;
  localparam int unsigned MAX_POSITIONS = 4096;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_CHANNELS   = 2'd0,
    CFG_POOL_POSITIONS = 2'd1,
    CFG_RECIPROCAL     = 2'd2
  } cfg_idx_e;

  // One classified sample on its way from the front end to the datapath.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            channel;
    logic                       first;
    logic                       last_pos;
    logic                       last_ch;
  } item_t;

endpackage

@@ rtl/gap_front.sv @@
// ----------------------------------------------------------------------------
// gap_front
// Accepts samples, tracks channel and position, tags each beat for the back.
// ----------------------------------------------------------------------------
module gap_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [gap_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [gap_pkg::NC_W-1:0]              num_channels_i,
  input  logic [gap_pkg::NP_W-1:0]              pool_positions_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output gap_pkg::item_t                        item_o
);

  logic [gap_pkg::CH_W-1:0]  chan_q, chan_d;
  logic [gap_pkg::POS_W-1:0] pos_q, pos_d;
  logic [gap_pkg::NC_W-1:0]  nc_eff;
  logic [gap_pkg::NP_W-1:0]  np_eff;
  logic [gap_pkg::CH_W-1:0]  chan;
  logic [gap_pkg::POS_W-1:0] np_last;
  logic                      last_ch;
  logic                      last_pos;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    // Clamp the counts to their legal range.
    if (num_channels_i == '0) begin
      nc_eff = gap_pkg::NC_W'(1);
    end else if (num_channels_i > gap_pkg::NC_W'(gap_pkg::MAX_CHANNELS)) begin
      nc_eff = gap_pkg::NC_W'(gap_pkg::MAX_CHANNELS);
    end else begin
      nc_eff = num_channels_i;
    end
    if (pool_positions_i == '0) begin
      np_eff = gap_pkg::NP_W'(1);
    end else if (pool_positions_i > gap_pkg::NP_W'(gap_pkg::MAX_POSITIONS)) begin
      np_eff = gap_pkg::NP_W'(gap_pkg::MAX_POSITIONS);
    end else begin
      np_eff = pool_positions_i;
    end

    // A channel counter left beyond a shrunk limit sits on the last channel.
    if ({1'b0, chan_q} >= nc_eff) begin
      chan = gap_pkg::CH_W'(nc_eff - 1'b1);
    end else begin
      chan = chan_q;
    end
    np_last  = gap_pkg::POS_W'(np_eff - 1'b1);
    last_ch  = ({1'b0, chan} + 1'b1) >= nc_eff;
    last_pos = ({1'b0, pos_q} + 1'b1) >= np_eff;

    if (last_ch) begin
      chan_d = '0;
      pos_d  = last_pos ? '0 : pos_q + 1'b1;
    end else begin
      chan_d = chan + 1'b1;
      pos_d  = last_pos ? np_last : pos_q;
    end

    item_o.sample   = sample_i;
    item_o.channel  = chan;
    item_o.first    = (pos_q == '0);
    item_o.last_pos = last_pos;
    item_o.last_ch  = last_ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      pos_q  <= '0;
    end else if (push_o) begin
      chan_q <= chan_d;
      pos_q  <= pos_d;
    end
  end

endmodule

@@ rtl/gap_queue.sv @@
// ----------------------------------------------------------------------------
// gap_queue
// Short FIFO of tagged beats between the front end and the datapath.
// ----------------------------------------------------------------------------
module gap_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gap_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gap_pkg::item_t head_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gap_pkg::item_t   slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/gap_back.sv @@
// ----------------------------------------------------------------------------
// gap_back
// Accumulates per channel, scales by the reciprocal, saturates, drives output.
// ----------------------------------------------------------------------------
module gap_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [gap_pkg::RECIP_W-1:0]          reciprocal_i,
  input  logic                                 q_empty_i,
  input  gap_pkg::item_t                       head_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [gap_pkg::SAMPLE_W-1:0]  average_o,
  output logic [gap_pkg::CH_W-1:0]             channel_o,
  output logic                                 batch_done_o
);

  localparam int unsigned SHIFT_W = gap_pkg::PROD_W - gap_pkg::FRAC_BITS;
  localparam int unsigned TOP_W   = SHIFT_W - gap_pkg::SAMPLE_W + 1;

  logic [gap_pkg::SUM_W-1:0] sum_mem [gap_pkg::MAX_CHANNELS];

  logic                              en;
  // Accumulate stage
  logic                              b_valid_q;
  gap_pkg::item_t                    b_item_q;
  logic [gap_pkg::SUM_W-1:0]         rd_q;
  logic                              hit_q;
  logic [gap_pkg::SUM_W-1:0]         fwd_q;
  logic [gap_pkg::SUM_W-1:0]         base;
  logic [gap_pkg::SUM_W-1:0]         sample_ext;
  logic [gap_pkg::SUM_W-1:0]         sum_b;
  logic signed [gap_pkg::PROD_W-1:0] prod_d;
  // Scale stage
  logic                              c_valid_q;
  logic signed [gap_pkg::PROD_W-1:0] prod_q;
  logic [gap_pkg::CH_W-1:0]          c_channel_q;
  logic                              c_last_ch_q;
  logic [SHIFT_W-1:0]                shifted;
  logic [TOP_W-1:0]                  top_bits;
  logic [gap_pkg::SAMPLE_W-1:0]      avg_d;
  // Output register
  logic                              out_valid_q;
  logic [gap_pkg::SAMPLE_W-1:0]      avg_q;
  logic [gap_pkg::CH_W-1:0]          out_channel_q;
  logic                              out_last_q;

  // The whole datapath advances together whenever the output slot frees up.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_empty_i;

  always_comb begin
    // Take the sum written on the same edge the read was issued.
    base       = hit_q ? fwd_q : rd_q;
    sample_ext = {{(gap_pkg::SUM_W - gap_pkg::SAMPLE_W){b_item_q.sample[gap_pkg::SAMPLE_W-1]}},
                  b_item_q.sample};
    sum_b      = b_item_q.first ? sample_ext : base + sample_ext;
    prod_d     = $signed(sum_b) * $signed({1'b0, reciprocal_i});

    // Floor shift, then clamp to the signed output range.
    shifted  = prod_q[gap_pkg::PROD_W-1:gap_pkg::FRAC_BITS];
    top_bits = shifted[SHIFT_W-1:gap_pkg::SAMPLE_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      avg_d = shifted[gap_pkg::SAMPLE_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      avg_d = {1'b1, {(gap_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      avg_d = {1'b0, {(gap_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && b_valid_q) begin
      sum_mem[b_item_q.channel] <= sum_b;
    end
    if (pop_o) begin
      rd_q <= sum_mem[head_i.channel];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_item_q      <= head_i;
      hit_q         <= b_valid_q && (head_i.channel == b_item_q.channel);
      fwd_q         <= sum_b;
      prod_q        <= prod_d;
      c_channel_q   <= b_item_q.channel;
      c_last_ch_q   <= b_item_q.last_ch;
      avg_q         <= avg_d;
      out_channel_q <= c_channel_q;
      out_last_q    <= c_last_ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q   <= pop_o;
      c_valid_q   <= b_valid_q && b_item_q.last_pos;
      out_valid_q <= c_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = $signed(avg_q);
  assign channel_o    = out_channel_q;
  assign batch_done_o = out_last_q;

endmodule

@@ rtl/global_average_pool_unit.sv @@
// ----------------------------------------------------------------------------
// global_average_pool_unit: per-channel mean over a streamed tensor.
// One sample per cycle unless the output stalls; one accumulator read-modify-write per beat.
// A batch's last sample passes the queue, accumulate stage, scale stage and output register.
// Reset clears counters, queue and valids; the sum memory keeps no reset value.
// ----------------------------------------------------------------------------
module global_average_pool_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [gap_pkg::SAMPLE_W-1:0]    sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [gap_pkg::SAMPLE_W-1:0]    average_o,
  output logic [gap_pkg::CH_W-1:0]               channel_o,
  output logic                                   batch_done_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gap_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [gap_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  logic [gap_pkg::NC_W-1:0]    num_channels_q;
  logic [gap_pkg::NP_W-1:0]    pool_positions_q;
  logic [gap_pkg::RECIP_W-1:0] reciprocal_q;

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  gap_pkg::item_t push_item;
  gap_pkg::item_t head_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q   <= gap_pkg::NC_W'(1);
      pool_positions_q <= gap_pkg::NP_W'(1);
      reciprocal_q     <= gap_pkg::RECIP_W'(65536);
    end else if (cfg_valid_i) begin
      case (gap_pkg::cfg_idx_e'(cfg_index_i))
        gap_pkg::CFG_NUM_CHANNELS: begin
          num_channels_q <= cfg_data_i[gap_pkg::NC_W-1:0];
        end
        gap_pkg::CFG_POOL_POSITIONS: begin
          pool_positions_q <= cfg_data_i[gap_pkg::NP_W-1:0];
        end
        gap_pkg::CFG_RECIPROCAL: begin
          reciprocal_q <= cfg_data_i[gap_pkg::RECIP_W-1:0];
        end
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  gap_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .num_channels_i   (num_channels_q),
    .pool_positions_i (pool_positions_q),
    .q_full_i         (q_full),
    .push_o           (push),
    .item_o           (push_item)
  );

  gap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  gap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reciprocal_i (reciprocal_q),
    .q_empty_i    (q_empty),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .average_o    (average_o),
    .channel_o    (channel_o),
    .batch_done_o (batch_done_o)
  );

endmodule

@@ rtl/gap_checker.sv @@
// ----------------------------------------------------------------------------
// gap_checker
// Port-level checks of the pooling unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "global_average_pool_unit_macros.svh"

module gap_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [gap_pkg::SAMPLE_W-1:0] average_o,
  input logic [gap_pkg::CH_W-1:0]            channel_o,
  input logic                                batch_done_o
);

  logic out_stall;
  assign out_stall = out_valid_o && !out_ready_i;

  // A stalled result beat keeps valid and payload.
  `GAP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable({average_o, channel_o, batch_done_o}), "result beat changed while stalled")

  // With the output slot free the datapath drains the queue, so input space opens.
  `GAP_ASSERT_NEXT(a_ready_recovers, !in_ready_o && !out_valid_o, in_ready_o, "input stayed blocked with a free output")

  // Leaving reset, the queue is empty and nothing is presented.
  `GAP_ASSERT_NOW(a_reset_clean, $rose(rst_ni), in_ready_o && !out_valid_o, "unit not clean out of reset")

  // An input beat can only be refused while results are backing up or just drained.
  `GAP_ASSERT_NOW(a_refuse_cause, in_valid_i && !in_ready_o, $past(out_valid_o) || out_valid_o, "input refused with no output backpressure")

endmodule

bind global_average_pool_unit gap_checker u_gap_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .average_o    (average_o),
  .channel_o    (channel_o),
  .batch_done_o (batch_done_o)
);

@@ sim/global_average_pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// global_average_pool_checker
// Watches the sample, average and register channels of the pooling unit.
// Keeps its own copy of the registers, the channel sums and the counters.
// Predicts each channel mean and compares it with the next average beat.
// ----------------------------------------------------------------------------
module global_average_pool_checker
  import gap_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [SAMPLE_W-1:0] average_i,
  input  logic [CH_W-1:0]            channel_i,
  input  logic                       batch_done_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  output int                         err_count_o,
  output int                         pending_o
);

  localparam logic [RECIP_W-1:0] RECIP_ONE = RECIP_W'(1 << FRAC_BITS);
  localparam longint AVG_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint AVG_MIN = -AVG_MAX - 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic [CH_W-1:0]            channel;
    logic                       batch_done;
  } mean_t;

  mean_t                 mean_q[$];
  logic [NC_W-1:0]       num_channels_q;
  logic [NP_W-1:0]       pool_positions_q;
  logic [RECIP_W-1:0]    reciprocal_q;
  logic signed [SUM_W-1:0] sum_mem [MAX_CHANNELS];
  int unsigned           ch_q;
  int unsigned           pos_q;
  int                    errs;

  // Fold one sample into its channel sum; queue a mean on the last position.
  task automatic accumulate(input logic signed [SAMPLE_W-1:0] x);
    int unsigned nc;
    int unsigned np;
    int unsigned c;
    int unsigned p;
    logic        last_ch;
    logic        last_pos;
    longint      acc;
    longint      prod;
    longint      q;
    mean_t       m;
    nc = num_channels_q;
    if (nc == 0) nc = 1;
    if (nc > MAX_CHANNELS) nc = MAX_CHANNELS;
    np = pool_positions_q;
    if (np == 0) np = 1;
    if (np > MAX_POSITIONS) np = MAX_POSITIONS;
    c = (ch_q >= nc) ? nc - 1 : ch_q;
    p = pos_q;
    last_ch  = (c + 1 >= nc);
    last_pos = (p + 1 >= np);
    acc = (p == 0) ? longint'(x) : longint'(sum_mem[c]) + longint'(x);
    sum_mem[c] = acc[SUM_W-1:0];
    if (last_pos) begin
      prod = longint'(sum_mem[c]) * longint'(reciprocal_q);
      q = prod >>> FRAC_BITS;
      if (q > AVG_MAX) q = AVG_MAX;
      if (q < AVG_MIN) q = AVG_MIN;
      m.average    = q[SAMPLE_W-1:0];
      m.channel    = c[CH_W-1:0];
      m.batch_done = last_ch;
      mean_q.push_back(m);
    end
    if (last_ch) begin
      ch_q  = 0;
      pos_q = last_pos ? 0 : p + 1;
    end else begin
      ch_q  = c + 1;
      pos_q = last_pos ? np - 1 : p;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mean_t want;
    mean_t got;
    if (!rst_ni) begin
      num_channels_q   = 1;
      pool_positions_q = 1;
      reciprocal_q     = RECIP_ONE;
      ch_q             = 0;
      pos_q            = 0;
      errs             = 0;
      mean_q.delete();
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_NUM_CHANNELS:   num_channels_q   = cfg_data_i[NC_W-1:0];
          CFG_POOL_POSITIONS: pool_positions_q = cfg_data_i[NP_W-1:0];
          CFG_RECIPROCAL:     reciprocal_q     = cfg_data_i[RECIP_W-1:0];
          default: ;
        endcase
      end
      // Compare before predicting so a stray beat cannot match a fresh entry.
      if (out_valid_i && out_ready_i) begin
        got.average    = average_i;
        got.channel    = channel_i;
        got.batch_done = batch_done_i;
        if (mean_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected average beat: got average %0d channel %0d batch_done %0b",
                   $time, got.average, got.channel, got.batch_done);
        end else begin
          want = mean_q.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: average mismatch: expected average %0d channel %0d batch_done %0b",
                     $time, want.average, want.channel, want.batch_done);
            $display("%0t:                   actual   average %0d channel %0d batch_done %0b",
                     $time, got.average, got.channel, got.batch_done);
          end
        end
      end
      if (in_valid_i && in_ready_i) accumulate(sample_i);
      pending_o   <= mean_q.size();
      err_count_o <= errs;
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pooling unit with directed and random sample streams under
// changing register settings, with random gaps on both channels and one long
// receiver stall. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import gap_pkg::*;

  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned TARGET_SAMPLES = 1250;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned STALL_SAMPLES  = 40;

  localparam logic [CFG_IDX_W-1:0]       CFG_UNUSED = {CFG_IDX_W{1'b1}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] average;
  logic [CH_W-1:0]            channel;
  logic                       batch_done;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         err_count;
  int                         pending;

  // Counter shadow, used only to keep register changes legal mid-batch.
  int unsigned mirror_nc    = 1;
  int unsigned mirror_np    = 1;
  int unsigned mirror_ch    = 0;
  int unsigned mirror_pos   = 0;
  bit          written [MAX_CHANNELS];
  int unsigned samples_sent = 0;
  int unsigned idle_cycles  = 0;
  bit          stall_req    = 1'b0;
  bit          stall_on     = 1'b0;

  global_average_pool_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_i     (sample),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .average_o    (average),
    .channel_o    (channel),
    .batch_done_o (batch_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  global_average_pool_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_i     (sample),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .average_i    (average),
    .channel_i    (channel),
    .batch_done_i (batch_done),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_count(input int unsigned raw, input int unsigned max);
    if (raw == 0) return 1;
    return (raw > max) ? max : raw;
  endfunction

  // Mostly short gaps, a few long ones; none in a steady stretch.
  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit heavy);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (heavy && r == 0) return SAMPLE_MAX;
    if (heavy && r == 1) return SAMPLE_MIN;
    return SAMPLE_W'($urandom());
  endfunction

  // Number of leading channel sums written since reset.
  function automatic int unsigned written_prefix();
    for (int unsigned i = 0; i < MAX_CHANNELS; i++)
      if (!written[i]) return i;
    return MAX_CHANNELS;
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int unsigned gap);
    int unsigned nc;
    int unsigned np;
    int unsigned c;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    nc = clamp_count(mirror_nc, MAX_CHANNELS);
    np = clamp_count(mirror_np, MAX_POSITIONS);
    c  = (mirror_ch >= nc) ? nc - 1 : mirror_ch;
    written[c] = 1'b1;
    if (c + 1 >= nc) begin
      mirror_ch  = 0;
      mirror_pos = (mirror_pos + 1 >= np) ? 0 : mirror_pos + 1;
    end else begin
      mirror_ch = c + 1;
      if (mirror_pos + 1 >= np) mirror_pos = np - 1;
    end
  endtask

  task automatic run_phase(input int unsigned count, input bit heavy, input bit steady);
    for (int unsigned i = 0; i < count; i++) send_sample(pick_sample(heavy), pick_gap(steady));
  endtask

  // Leaves cfg_valid high; the caller drops it after the last beat.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUM_CHANNELS) mirror_nc = data[NC_W-1:0];
    else if (idx == CFG_POOL_POSITIONS) mirror_np = data[NP_W-1:0];
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] nc, input logic [CFG_DATA_W-1:0] np,
                           input logic [CFG_DATA_W-1:0] recip, input bit poke_unused);
    in_valid <= 1'b0;
    // Hold until every average is out, then let the pipeline settle.
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_NUM_CHANNELS, nc);
    write_reg(CFG_POOL_POSITIONS, np);
    write_reg(CFG_RECIPROCAL, recip);
    if (poke_unused) write_reg(CFG_UNUSED, {CFG_DATA_W{1'b1}} & CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random holds, long ready stretches, one long stall on request.
  initial begin
    int unsigned hold;
    int unsigned run;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = pick_gap(1'b0);
      if (stall_req && !stall_on) begin
        hold     = STALL_CYCLES;
        stall_on = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      for (int unsigned i = 0; i < run; i++) begin
        @(posedge clk);
        // Cut the stretch short once the long stall is asked for.
        if (stall_req && !stall_on) break;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int unsigned r;
    int unsigned nc_raw;
    int unsigned np_raw;
    int unsigned np_eff;
    int unsigned batch;
    int unsigned len;
    int unsigned limit;
    logic [CFG_DATA_W-1:0] recip;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    sample    <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NUM_CHANNELS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one channel, one position, unity reciprocal.
    send_sample(SAMPLE_MAX, pick_gap(1'b0));
    send_sample(SAMPLE_MIN, pick_gap(1'b0));
    send_sample(0, pick_gap(1'b0));
    send_sample(1, pick_gap(1'b0));
    send_sample(-1, pick_gap(1'b0));

    configure(3, 2, CFG_DATA_W'(1 << (FRAC_BITS - 1)), 1'b0);
    send_sample(SAMPLE_MAX, pick_gap(1'b0));
    send_sample(SAMPLE_MIN, pick_gap(1'b0));
    send_sample(1, pick_gap(1'b0));
    send_sample(SAMPLE_MAX, pick_gap(1'b0));
    send_sample(SAMPLE_MIN, pick_gap(1'b0));
    send_sample(-1, pick_gap(1'b0));

    // Reciprocal above one: drive both saturation rails.
    configure(1, 4, {CFG_DATA_W{1'b1}}, 1'b0);
    repeat (4) send_sample(SAMPLE_MAX, pick_gap(1'b0));
    repeat (4) send_sample(SAMPLE_MIN, pick_gap(1'b0));

    // Zero counts act as one; zero reciprocal; poke the unused index.
    configure(0, 0, 0, 1'b1);
    send_sample(SAMPLE_W'(16'h5555), pick_gap(1'b0));
    send_sample(SAMPLE_W'(16'haaaa), pick_gap(1'b0));

    // Oversized counts clamp; then shrink mid-batch so the counter wraps.
    configure({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, 16, 1'b0);
    repeat (3) send_sample(pick_sample(1'b1), pick_gap(1'b0));
    configure(1, 1, CFG_DATA_W'(1 << FRAC_BITS), 1'b0);
    send_sample(pick_sample(1'b1), pick_gap(1'b0));

    // One average per beat while the receiver holds off, so the input backs up.
    configure(1, 1, CFG_DATA_W'(1 << FRAC_BITS), 1'b0);
    stall_req = 1'b1;
    wait (stall_on);
    run_phase(STALL_SAMPLES, 1'b0, 1'b1);

    while (samples_sent < TARGET_SAMPLES) begin
      r = $urandom_range(0, 9);
      nc_raw = (r < 6) ? $urandom_range(1, 8) : (r < 9) ? $urandom_range(9, 40)
                                                        : $urandom_range(0, 2047);
      r = $urandom_range(0, 9);
      np_raw = (r < 6) ? $urandom_range(1, 8) : (r < 9) ? $urandom_range(9, 32)
                                                        : $urandom_range(0, 8191);
      // Mid-batch, never widen past the sums written so far.
      if (mirror_pos != 0) begin
        limit = written_prefix();
        if (clamp_count(nc_raw, MAX_CHANNELS) > limit) nc_raw = limit;
      end
      np_eff = clamp_count(np_raw, MAX_POSITIONS);
      if ($urandom_range(0, 3) == 0) recip = CFG_DATA_W'($urandom_range(0, 131071));
      else recip = CFG_DATA_W'(((1 << FRAC_BITS) + np_eff / 2) / np_eff);
      configure(CFG_DATA_W'(nc_raw), CFG_DATA_W'(np_raw), recip, $urandom_range(0, 15) == 0);
      batch = clamp_count(nc_raw, MAX_CHANNELS) * np_eff;
      if ($urandom_range(0, 3) != 0 && batch <= 200)
        len = batch * $urandom_range(1, 200 / batch);
      else
        len = $urandom_range(1, 60);
      run_phase(len, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
